// ----- design/error_diffusion_palette_dither_unit_assert.svh -----
// Assertion macros shared by the dither unit.
`ifndef ERROR_DIFFUSION_PALETTE_DITHER_UNIT_ASSERT_SVH
`define ERROR_DIFFUSION_PALETTE_DITHER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define EDPD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the cycle after.
`define EDPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/edpd_pkg.sv -----
// ----------------------------------------------------------------------------
// Dither unit package
// Opcodes, register indexes, sizes and saturating helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package edpd_pkg;

  localparam int MaxWidth    = 2048;
  localparam int MaxHeight   = 2048;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int RowW        = $clog2(MaxHeight);
  localparam int ErrW        = 10;
  localparam int TableDepth  = 65536;
  localparam int PalDepth    = 256;

  localparam logic [1:0] OpPixel   = 2'd0;
  localparam logic [1:0] OpPalette = 2'd1;
  localparam logic [1:0] OpTable   = 2'd2;

  localparam logic CfgFrameWidth  = 1'b0;
  localparam logic CfgFrameHeight = 1'b1;

  typedef logic signed [ErrW-1:0] err_t;

  function automatic err_t sat_err(input logic signed [11:0] v);
    logic signed [11:0] lo;
    logic signed [11:0] hi;
    lo = -12'sd512;
    hi = 12'sd511;
    if (v < lo) begin
      sat_err = -10'sd512;
    end else if (v > hi) begin
      sat_err = 10'sd511;
    end else begin
      sat_err = v[ErrW-1:0];
    end
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    if (v < 12'sd0) begin
      clamp8 = 8'd0;
    end else if (v > 12'sd255) begin
      clamp8 = 8'd255;
    end else begin
      clamp8 = v[7:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/edpd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and a read of
// an address written in the same cycle returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module edpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(Depth)-1:0] waddr_i,
  input  wire  [Width-1:0]         wdata_i,
  input  wire  [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/error_diffusion_palette_dither_unit.sv -----
// ----------------------------------------------------------------------------
// Error-diffusion palette dither unit
// Maps RGB565 pixels to palette indexes with Floyd-Steinberg error spread.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one beat per command: a pixel, a palette colour
// write or an index table write. Only pixels produce an output beat, which
// holds the palette index and the end of row and end of frame flags.
// The configuration channel writes frame width (index 0) and frame height
// (index 1); it is always ready.
// A pixel passes the table read stage and the error stage, then the output
// buffer, on its way to the output beat. A new pixel is not taken while the
// last one is in its table read stage: the loop from index table read,
// through palette read and error, to the next pixel's table key keeps them
// apart. At each row end the row error buffer makes its final write-back
// before the next pixel. Table and palette writes are never held off.
// Reset clears position, pending errors and registers (width and height 1);
// table and palette contents are undefined until written. A stalled receiver
// is absorbed by a two-beat output buffer, after which pixels are held off.
// ----------------------------------------------------------------------------
`default_nettype none

`include "error_diffusion_palette_dither_unit_assert.svh"

module error_diffusion_palette_dither_unit (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire         cfg_index_i,
  input  wire  [11:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [1:0]  in_opcode_i,
  input  wire  [15:0] in_pixel_i,
  input  wire  [7:0]  in_palette_slot_i,
  input  wire  [7:0]  in_red_i,
  input  wire  [7:0]  in_green_i,
  input  wire  [7:0]  in_blue_i,
  input  wire  [15:0] in_table_address_i,
  input  wire  [7:0]  in_table_value_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  out_palette_index_o,
  output logic        out_end_of_row_o,
  output logic        out_end_of_frame_o
);
  import edpd_pkg::*;

  logic [11:0] width_q, height_q, w_eff, h_eff;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW:0] prev_len_q;
  logic rd_ok_q;

  logic p_v_q, e_v_q, ext_q;
  logic [7:0] p_ch_q [3];
  logic [7:0] e_ch_q [3];
  logic [ColW-1:0] p_x_q, e_x_q, ext_addr_q;
  logic p_row_end_q, p_last_q, e_row_end_q, e_last_q;
  logic [7:0] e_idx_q;
  logic [29:0] ext_data_q;
  err_t c7_q [3];
  err_t a_q [3];
  err_t b_q [3];

  logic [1:0] out_cnt_q;
  logic out_wp_q, out_rp_q;
  logic [9:0] out_ent_q [2];

  logic [7:0]  idx_rdata;
  logic [23:0] pal_rdata;
  logic [29:0] row_rdata;
  logic [15:0] key;
  logic        k_fire, pix_can, is_pix, row_end, bottom_row;
  logic        row_we;
  logic [ColW-1:0] row_waddr;
  logic [29:0] row_wdata;
  logic [7:0]  ch [3];
  err_t r7 [3];
  err_t a_new [3];
  err_t b_new [3];
  err_t c_new [3];
  logic push, pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    w_eff = (width_q == 12'd0) ? 12'd1 :
            (width_q > 12'(MaxWidth)) ? 12'(MaxWidth) : width_q;
    h_eff = (height_q == 12'd0) ? 12'd1 :
            (height_q > 12'(MaxHeight)) ? 12'(MaxHeight) : height_q;
    row_end    = ({1'b0, col_q} + 12'd1) >= w_eff;
    bottom_row = ({1'b0, row_q} + 12'd1) >= h_eff;
  end

  assign is_pix  = (in_opcode_i == OpPixel);
  assign pix_can = !p_v_q && !(e_v_q && e_row_end_q) && !ext_q && rd_ok_q &&
                   (({1'b0, e_v_q} + out_cnt_q) < 2'd2);
  assign in_ready_o = !is_pix || pix_can;
  assign k_fire = in_valid_i && in_ready_o && is_pix;

  // Error of the pixel in the last stage, with its spread weights.
  always_comb begin
    logic signed [9:0]  e;
    logic signed [12:0] t7, t3, t5;
    logic signed [12:0] t1;
    err_t d3, d5, d1;
    for (int c = 0; c < 3; c++) begin
      e  = $signed({2'b00, e_ch_q[c]}) - $signed({2'b00, pal_rdata[23-8*c -: 8]});
      t7 = {{3{e[9]}}, e} * 13'sd7;
      t3 = {{3{e[9]}}, e} * 13'sd3;
      t5 = {{3{e[9]}}, e} * 13'sd5;
      t1 = {{3{e[9]}}, e};
      r7[c] = e_row_end_q ? '0 : 10'(t7 >>> 4);
      d3 = e_last_q ? '0 : 10'(t3 >>> 4);
      d5 = e_last_q ? '0 : 10'(t5 >>> 4);
      d1 = (e_last_q || e_row_end_q) ? '0 : 10'(t1 >>> 4);
      a_new[c] = sat_err({{2{a_q[c][9]}}, a_q[c]} + {{2{d3[9]}}, d3});
      b_new[c] = sat_err({{2{b_q[c][9]}}, b_q[c]} + {{2{d5[9]}}, d5});
      c_new[c] = d1;
    end
  end

  // Colour of the entering pixel with its pending error.
  always_comb begin
    logic [13:0] wr, wg, wb;
    logic [7:0]  wide [3];
    err_t bufv, carry, cur;
    wr = 14'(in_pixel_i[15:11]) * 14'd527 + 14'd23;
    wg = 14'(in_pixel_i[10:5]) * 14'd259 + 14'd33;
    wb = 14'(in_pixel_i[4:0]) * 14'd527 + 14'd23;
    wide[0] = wr[13:6];
    wide[1] = wg[13:6];
    wide[2] = wb[13:6];
    for (int c = 0; c < 3; c++) begin
      bufv  = ({1'b0, col_q} < prev_len_q) ? err_t'(row_rdata[29-10*c -: 10]) : '0;
      carry = e_v_q ? r7[c] : c7_q[c];
      cur   = sat_err({{2{bufv[9]}}, bufv} + {{2{carry[9]}}, carry});
      ch[c] = clamp8({4'b0000, wide[c]} + {{2{cur[9]}}, cur});
    end
    key = {ch[0][7:3], ch[1][7:2], ch[2][7:3]};
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (k_fire) begin
      if (row_end && bottom_row) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  assign row_we    = (e_v_q && (e_x_q != '0)) || ext_q;
  assign row_waddr = ext_q ? ext_addr_q : e_x_q - 1'b1;
  assign row_wdata = ext_q ? ext_data_q : {a_new[0], a_new[1], a_new[2]};

  assign push = e_v_q;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= 12'd1;
      height_q   <= 12'd1;
      col_q      <= '0;
      row_q      <= '0;
      prev_len_q <= '0;
      rd_ok_q    <= 1'b0;
      p_v_q      <= 1'b0;
      e_v_q      <= 1'b0;
      ext_q      <= 1'b0;
      out_cnt_q  <= '0;
      out_wp_q   <= 1'b0;
      out_rp_q   <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        c7_q[c] <= '0;
        b_q[c]  <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgFrameWidth:  width_q  <= cfg_data_i;
          CfgFrameHeight: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q   <= col_d;
      row_q   <= row_d;
      rd_ok_q <= (col_d == col_q) && !(row_we && (row_waddr == col_q));
      p_v_q   <= k_fire;
      e_v_q   <= p_v_q;
      ext_q   <= e_v_q && e_row_end_q;
      if (e_v_q) begin
        for (int c = 0; c < 3; c++) begin
          c7_q[c] <= r7[c];
          b_q[c]  <= c_new[c];
        end
        if (e_row_end_q) begin
          prev_len_q <= e_last_q ? '0 : {1'b0, e_x_q} + 1'b1;
        end
      end
      if (push) begin
        out_wp_q <= ~out_wp_q;
      end
      if (pop) begin
        out_rp_q <= ~out_rp_q;
      end
      out_cnt_q <= out_cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (k_fire) begin
      p_ch_q      <= ch;
      p_x_q       <= col_q;
      p_row_end_q <= row_end;
      p_last_q    <= bottom_row;
    end
    if (p_v_q) begin
      e_ch_q      <= p_ch_q;
      e_x_q       <= p_x_q;
      e_row_end_q <= p_row_end_q;
      e_last_q    <= p_last_q;
      e_idx_q     <= idx_rdata;
    end
    if (e_v_q) begin
      a_q        <= b_new;
      ext_addr_q <= e_x_q;
      ext_data_q <= {b_new[0], b_new[1], b_new[2]};
    end
    if (push) begin
      out_ent_q[out_wp_q] <= {e_idx_q, e_row_end_q, e_row_end_q && e_last_q};
    end
  end

  assign out_valid_o         = (out_cnt_q != '0);
  assign out_palette_index_o = out_ent_q[out_rp_q][9:2];
  assign out_end_of_row_o    = out_ent_q[out_rp_q][1];
  assign out_end_of_frame_o  = out_ent_q[out_rp_q][0];

  edpd_ram #(.Width(8), .Depth(TableDepth)) u_index_table (
    .clk_i   (clk_i),
    .we_i    (in_valid_i && in_ready_o && (in_opcode_i == OpTable)),
    .waddr_i (in_table_address_i),
    .wdata_i (in_table_value_i),
    .raddr_i (key),
    .rdata_o (idx_rdata)
  );

  edpd_ram #(.Width(24), .Depth(PalDepth)) u_palette (
    .clk_i   (clk_i),
    .we_i    (in_valid_i && in_ready_o && (in_opcode_i == OpPalette)),
    .waddr_i (in_palette_slot_i),
    .wdata_i ({in_red_i, in_green_i, in_blue_i}),
    .raddr_i (idx_rdata),
    .rdata_o (pal_rdata)
  );

  edpd_ram #(.Width(30), .Depth(MaxWidth)) u_row_error (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (col_q),
    .rdata_o (row_rdata)
  );

  `EDPD_ASSERT_NOW(a_out_no_overflow, out_cnt_q != 2'd0, out_cnt_q <= 2'd2, "output buffer overflow")
  `EDPD_ASSERT_NOW(a_pix_stage_free, k_fire, !p_v_q && !ext_q, "pixel entered a busy stage")
  `EDPD_ASSERT_NEXT(a_stage_advance, p_v_q, e_v_q, "pixel lost between stages")
  `EDPD_ASSERT_NOW(a_ext_alone, ext_q, !e_v_q, "row write-back clashed with a pixel")

endmodule

`default_nettype wire

// ----- test/dither_scoreboard.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither unit scoreboard
// Watches the configuration, input and output channels of the dither unit,
// keeps its own copy of the tables, palette, error rows and position, and
// compares every output beat with the oldest predicted index and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module dither_scoreboard
  import edpd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  input  wire         cfg_ready_i,
  input  wire         cfg_index_i,
  input  wire  [11:0] cfg_data_i,
  input  wire         in_valid_i,
  input  wire         in_ready_i,
  input  wire  [1:0]  in_opcode_i,
  input  wire  [15:0] in_pixel_i,
  input  wire  [7:0]  in_palette_slot_i,
  input  wire  [7:0]  in_red_i,
  input  wire  [7:0]  in_green_i,
  input  wire  [7:0]  in_blue_i,
  input  wire  [15:0] in_table_address_i,
  input  wire  [7:0]  in_table_value_i,
  input  wire         out_valid_i,
  input  wire         out_ready_i,
  input  wire  [7:0]  out_palette_index_i,
  input  wire         out_end_of_row_i,
  input  wire         out_end_of_frame_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [7:0] index;
    logic       row_end;
    logic       frame_end;
  } dither_beat_t;

  int unsigned  width_reg;
  int unsigned  height_reg;
  int unsigned  col;
  int unsigned  row;
  logic [7:0]   index_tab [TableDepth];
  logic [23:0]  palette   [PalDepth];
  int           cur_err   [MaxWidth][3];
  int           nxt_err   [MaxWidth][3];
  dither_beat_t expected_beats [$];

  function automatic int sat_add(int a, int b);
    int s;
    s = a + b;
    if (s < -512) s = -512;
    if (s > 511) s = 511;
    return s;
  endfunction

  // Table key that the next pixel would use with the present error state.
  function automatic logic [15:0] peek_key(logic [15:0] px);
    int unsigned  x;
    int           ch [3];
    logic [7:0]   c8 [3];
    x = col % MaxWidth;
    ch[0] = (int'(px[15:11]) * 527 + 23) >> 6;
    ch[1] = (int'(px[10:5]) * 259 + 33) >> 6;
    ch[2] = (int'(px[4:0]) * 527 + 23) >> 6;
    for (int c = 0; c < 3; c++) begin
      ch[c] = ch[c] + cur_err[x][c];
      if (ch[c] < 0) ch[c] = 0;
      if (ch[c] > 255) ch[c] = 255;
      c8[c] = ch[c][7:0];
    end
    return {c8[0][7:3], c8[1][7:2], c8[2][7:3]};
  endfunction

  function automatic void dither_pixel(logic [15:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  x;
    bit           row_end;
    bit           bottom_row;
    bit           has_right;
    int           ch [3];
    logic [7:0]   c8 [3];
    logic [15:0]  key;
    logic [7:0]   idx;
    logic [23:0]  pc;
    int           e;
    dither_beat_t b;
    w = (width_reg == 0) ? 1 : ((width_reg > MaxWidth) ? MaxWidth : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MaxHeight) ? MaxHeight : height_reg);
    x = col % MaxWidth;
    row_end = (col + 1 >= w);
    bottom_row = (row + 1 >= h);
    has_right = !row_end && (x + 1 < MaxWidth);
    ch[0] = (int'(px[15:11]) * 527 + 23) >> 6;
    ch[1] = (int'(px[10:5]) * 259 + 33) >> 6;
    ch[2] = (int'(px[4:0]) * 527 + 23) >> 6;
    for (int c = 0; c < 3; c++) begin
      ch[c] = ch[c] + cur_err[x][c];
      if (ch[c] < 0) ch[c] = 0;
      if (ch[c] > 255) ch[c] = 255;
      c8[c] = ch[c][7:0];
    end
    key = {c8[0][7:3], c8[1][7:2], c8[2][7:3]};
    idx = index_tab[key];
    pc = palette[idx];
    for (int c = 0; c < 3; c++) begin
      e = ch[c] - int'(pc[23-8*c -: 8]);
      if (has_right) cur_err[x+1][c] = sat_add(cur_err[x+1][c], (e * 7) >>> 4);
      if (!bottom_row) begin
        if (x > 0) nxt_err[x-1][c] = sat_add(nxt_err[x-1][c], (e * 3) >>> 4);
        nxt_err[x][c] = sat_add(nxt_err[x][c], (e * 5) >>> 4);
        if (has_right) nxt_err[x+1][c] = sat_add(nxt_err[x+1][c], e >>> 4);
      end
    end
    if (row_end && bottom_row) begin
      foreach (cur_err[i, c]) begin
        cur_err[i][c] = 0;
        nxt_err[i][c] = 0;
      end
      col = 0;
      row = 0;
    end else if (row_end) begin
      foreach (cur_err[i, c]) begin
        cur_err[i][c] = nxt_err[i][c];
        nxt_err[i][c] = 0;
      end
      col = 0;
      row++;
    end else begin
      col++;
    end
    b.index = idx;
    b.row_end = row_end;
    b.frame_end = row_end && bottom_row;
    expected_beats.push_back(b);
  endfunction

  assign pending_o = expected_beats.size();

  always @(posedge clk_i or negedge rst_ni) begin
    dither_beat_t b;
    if (!rst_ni) begin
      width_reg = 1;
      height_reg = 1;
      col = 0;
      row = 0;
      fail_count_o = 0;
      foreach (cur_err[i, c]) begin
        cur_err[i][c] = 0;
        nxt_err[i][c] = 0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CfgFrameWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected output beat, index %0d", out_palette_index_i);
          fail_count_o++;
        end else begin
          b = expected_beats.pop_front();
          if (out_palette_index_i !== b.index) begin
            $error("palette_index: expected %0d, actual %0d", b.index, out_palette_index_i);
            fail_count_o++;
          end
          if (out_end_of_row_i !== b.row_end) begin
            $error("end_of_row: expected %0d, actual %0d", b.row_end, out_end_of_row_i);
            fail_count_o++;
          end
          if (out_end_of_frame_i !== b.frame_end) begin
            $error("end_of_frame: expected %0d, actual %0d", b.frame_end,
                   out_end_of_frame_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_opcode_i)
          OpPixel:   dither_pixel(in_pixel_i);
          OpPalette: palette[in_palette_slot_i] = {in_red_i, in_green_i, in_blue_i};
          OpTable:   index_tab[in_table_address_i] = in_table_value_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dither unit testbench
// Loads part of the palette and writes index table entries as the pixels
// come to need them, then runs directed and random pixel streams over a
// range of frame sizes with random idling on both sides and one long output
// stall; the scoreboard checks every output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import edpd_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int SettleCycles = 20;
  localparam int CycleLimit = 200000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [11:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  in_opcode_i = OpPixel;
  logic [15:0] in_pixel_i = '0;
  logic [7:0]  in_palette_slot_i = '0;
  logic [7:0]  in_red_i = '0;
  logic [7:0]  in_green_i = '0;
  logic [7:0]  in_blue_i = '0;
  logic [15:0] in_table_address_i = '0;
  logic [7:0]  in_table_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_palette_index_o;
  logic        out_end_of_row_o;
  logic        out_end_of_frame_o;
  int          fail_count;
  int          pending;
  bit          calm = 1'b1;
  bit          squeeze = 1'b0;
  int          cycles = 0;
  bit          tab_written [TableDepth];
  bit          pal_written [PalDepth];
  int          pal_slots [$];

  always #5 clk_i = ~clk_i;

  error_diffusion_palette_dither_unit u_dut (.*);

  dither_scoreboard u_scoreboard (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .in_opcode_i, .in_pixel_i, .in_palette_slot_i,
    .in_red_i, .in_green_i, .in_blue_i, .in_table_address_i, .in_table_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_palette_index_i(out_palette_index_o),
    .out_end_of_row_i(out_end_of_row_o), .out_end_of_frame_i(out_end_of_frame_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (squeeze) begin
        out_ready_i = 1'b0;
        repeat (400) @(negedge clk_i);
        squeeze = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_beat(logic [1:0] op, logic [15:0] px, logic [7:0] slot,
                           logic [23:0] rgb, logic [15:0] addr, logic [7:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_opcode_i = op;
    in_pixel_i = px;
    in_palette_slot_i = slot;
    {in_red_i, in_green_i, in_blue_i} = rgb;
    in_table_address_i = addr;
    in_table_value_i = val;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_slot();
    return 8'(pal_slots[$urandom_range(0, pal_slots.size() - 1)]);
  endfunction

  task automatic write_palette(logic [7:0] slot, logic [23:0] rgb);
    if (!pal_written[slot]) begin
      pal_written[slot] = 1'b1;
      pal_slots.push_back(int'(slot));
    end
    send_beat(OpPalette, 16'($urandom), slot, rgb, 16'($urandom), 8'($urandom));
  endtask

  task automatic write_table(logic [15:0] addr, logic [7:0] val);
    tab_written[addr] = 1'b1;
    send_beat(OpTable, 16'($urandom), 8'($urandom), 24'($urandom), addr, val);
  endtask

  task automatic send_pixel(logic [15:0] px);
    logic [15:0] key;
    key = u_scoreboard.peek_key(px);
    if (!tab_written[key]) write_table(key, pick_slot());
    send_beat(OpPixel, px, 8'($urandom), 24'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic write_frame_size(logic [11:0] w, logic [11:0] h);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = CfgFrameWidth;
    cfg_data_i = w;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_index_i = CfgFrameHeight;
    cfg_data_i = h;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_beats(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) send_pixel(16'($urandom));
      else if (pick < 80) write_palette(8'($urandom), 24'($urandom));
      else if (pick < 95) write_table(16'($urandom), pick_slot());
      else send_beat(OpUnused, 16'($urandom), 8'($urandom), 24'($urandom),
                     16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [15:0] corner_pixels [8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                       16'h001F, 16'h8410, 16'h7BEF, 16'h0821};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    for (int s = 0; s < 16; s++) begin
      write_palette(s[7:0], 24'($urandom));
    end
    write_palette(8'd0, 24'h000000);
    write_palette(8'd255, 24'hFFFFFF);
    write_table(16'h0000, 8'd255);
    write_table(16'hFFFF, 8'd0);
    write_frame_size(12'd3, 12'd3);
    foreach (corner_pixels[i]) send_pixel(corner_pixels[i]);
    send_beat(OpUnused, 16'hFFFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 8'hFF);
    send_pixel(16'hFFFF);
    write_frame_size(12'd0, 12'd0);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    write_frame_size(12'd1, 12'd4);
    send_pixel(16'hFFFF);
    send_pixel(16'h0000);
    calm = 1'b0;
    for (int p = 0; p < 6; p++) begin
      write_frame_size(12'($urandom_range(1, 12)), 12'($urandom_range(1, 6)));
      if (p == 2) squeeze = 1'b1;
      random_beats(30);
    end
    write_frame_size(12'd4095, 12'd2);
    for (int i = 0; i < 10; i++) send_pixel(16'($urandom));
    write_frame_size(12'd5, 12'd4095);
    random_beats(15);
    write_frame_size(12'd6, 12'd4);
    calm = 1'b1;
    random_beats(25);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
